/* design/frsc_pkg.sv */
// Package for the frame receiver with additive checksum.
// Holds the event codes, the result record and the header constants.
// No dependencies.
package frsc_pkg;

  typedef enum logic [2:0] {
    EV_HDR_OK   = 3'd0,
    EV_HDR_BAD  = 3'd1,
    EV_LENGTH   = 3'd2,
    EV_PAYLOAD  = 3'd3,
    EV_GOOD     = 3'd4,
    EV_CKS_BAD  = 3'd5,
    EV_OVERFLOW = 3'd6
  } event_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic [7:0] command_byte;
  } result_t;

  localparam logic [7:0] HDR_TAG_MASK  = 8'hF0;
  localparam logic [7:0] HDR_LEN_FLAG  = 8'h01;
  localparam int         TAG_W         = 4;
  localparam int         BYTE_W        = 8;

endpackage

/* design/frsc_parser.sv */
// Frame parser: holds the frame state and classifies one byte per step.
// Produces the result record combinationally; the state advances on step.
// Depends on frsc_pkg.
module frsc_parser #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [frsc_pkg::BYTE_W-1:0]      rx_byte,
  input  logic [frsc_pkg::TAG_W-1:0]       header_tag,
  output frsc_pkg::result_t                result
);
  import frsc_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              has_len_r, has_len_nxt;
  logic [7:0]        plen_r, plen_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        first_r, first_nxt;

  logic [CMP_W-1:0]  p_ext;
  logic [CMP_W-1:0]  pay_start;
  logic [CMP_W-1:0]  cks_pos;
  logic [7:0]        sum_add;
  logic              clear;

  always_comb begin
    p_ext     = CMP_W'(pos_r);
    pay_start = CMP_W'(has_len_r) + CMP_W'(1);
    cks_pos   = CMP_W'(plen_r) + CMP_W'(has_len_r) + CMP_W'(1);
    sum_add   = sum_r + rx_byte;

    clear       = 1'b0;
    pos_nxt     = pos_r;
    has_len_nxt = has_len_r;
    plen_nxt    = plen_r;
    sum_nxt     = sum_r;
    first_nxt   = first_r;

    result.event_res     = EV_OVERFLOW;
    result.data_byte     = rx_byte;
    result.payload_index = '0;
    result.frame_length  = plen_r;
    result.command_byte  = '0;

    priority if (p_ext + CMP_W'(1) >= CMP_W'(MAX_FRAME_BYTES)) begin
      result.event_res = EV_OVERFLOW;
      clear = 1'b1;
    end else if (pos_r == '0) begin
      result.frame_length = '0;
      if ((rx_byte & HDR_TAG_MASK) == {header_tag, 4'h0}) begin
        result.event_res = EV_HDR_OK;
        has_len_nxt = |(rx_byte & HDR_LEN_FLAG);
        sum_nxt     = rx_byte;
        pos_nxt     = POS_W'(1);
      end else begin
        result.event_res = EV_HDR_BAD;
        clear = 1'b1;
      end
    end else if (has_len_r && p_ext == CMP_W'(1)) begin
      result.event_res    = EV_LENGTH;
      result.frame_length = rx_byte;
      plen_nxt = rx_byte;
      sum_nxt  = sum_add;
      pos_nxt  = pos_r + POS_W'(1);
    end else if (p_ext >= pay_start && p_ext < cks_pos) begin
      result.event_res     = EV_PAYLOAD;
      result.payload_index = 8'(p_ext - pay_start);
      if (p_ext == pay_start) begin
        first_nxt = rx_byte;
      end
      sum_nxt = sum_add;
      pos_nxt = pos_r + POS_W'(1);
    end else if (p_ext == cks_pos) begin
      if (sum_r == rx_byte) begin
        result.event_res = EV_GOOD;
        if (plen_r != 8'd0) begin
          result.command_byte = first_r;
        end
      end else begin
        result.event_res = EV_CKS_BAD;
      end
      clear = 1'b1;
    end else begin
      result.event_res = EV_OVERFLOW;
      clear = 1'b1;
    end

    if (clear) begin
      pos_nxt     = '0;
      has_len_nxt = 1'b0;
      plen_nxt    = '0;
      sum_nxt     = '0;
      first_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      has_len_r <= 1'b0;
      plen_r    <= '0;
      sum_r     <= '0;
      first_r   <= '0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      has_len_r <= has_len_nxt;
      plen_r    <= plen_nxt;
      sum_r     <= sum_nxt;
      first_r   <= first_nxt;
    end
  end

endmodule

/* design/frame_receiver_sum_checksum.sv */
// Frame receiver with 8-bit additive checksum: top level.
// An input byte is held in the input register; its result is then registered
// in the result register. Throughput: one byte per cycle while out_tready does
// not stall the output; the parser step lies between the two registers.
// Reset (rst_n, synchronous, active low) clears the frame state, the tag
// register and both valid flags. Depends on frsc_pkg and frsc_parser.
module frame_receiver_sum_checksum #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [15:8] payload_index,
                                  // [23:16] frame_length, [31:24] command_byte
  output logic [2:0]  out_tuser,  // [2:0] event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data    // [3:0] header_tag
);
  import frsc_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [TAG_W-1:0]  tag_r;
  logic              out_valid_r;
  result_t           out_r;
  result_t           res;
  logic              advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (cfg_valid) begin
      tag_r <= cfg_data;
    end
  end

  frsc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .header_tag (tag_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.event_res;
  assign out_tdata  = {out_r.command_byte, out_r.frame_length,
                       out_r.payload_index, out_r.data_byte};

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  // A byte leaving the input register must appear as a result.
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced byte did not reach the result register");

  // The payload index is only reported for payload bytes.
  a_index_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser != EV_PAYLOAD) |-> (out_tdata[15:8] == 8'd0))
    else $error("payload index set outside a payload transfer");

  // The command byte is only reported with a good frame.
  a_cmd_good_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser != EV_GOOD) |-> (out_tdata[31:24] == 8'd0))
    else $error("command byte set outside a good frame");

endmodule

/* sim/frame_receiver_sum_checksum_tb.sv */
// Self-checking testbench for the frame receiver with additive checksum.
// Streams directed and random frames, predicts each status result in step
// with the input transfers and checks the results. Depends on frsc_pkg and frame_receiver_sum_checksum.
`timescale 1ns / 100ps

module frame_receiver_sum_checksum_tb;
  import frsc_pkg::*;

  localparam int FRAME_BOUND   = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 1000;
  localparam int PHASE_ITEMS   = 240;

  typedef struct {
    bit         is_cfg;
    bit         steady;
    logic [7:0] value;
  } stim_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data   = '0;

  frame_receiver_sum_checksum #(
    .MAX_FRAME_BYTES(FRAME_BOUND)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  stim_t   pending[$];
  result_t expected_status[$];
  int      errors       = 0;
  int      quiet_cycles = 0;
  int      idle_cycles  = 0;
  int      in_gap       = 0;
  int      stall_left   = 0;
  int      sink_cycles  = 0;
  bit      sink_steady  = 1'b0;
  logic    in_acc       = 1'b0;
  logic    cfg_acc      = 1'b0;

  // Shadow copy of the receiver's tag register and frame state.
  logic [3:0] hdr_tag     = '0;
  int         frm_pos     = 0;
  bit         frm_has_len = 1'b0;
  logic [7:0] frm_len     = '0;
  logic [7:0] frm_sum     = '0;
  logic [7:0] frm_cmd     = '0;

  // Stimulus generation state.
  logic [3:0] gen_tag    = '0;
  bit         gen_steady = 1'b0;
  int         stim_count = 0;

  task automatic report_fault(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_frame();
    frm_pos     = 0;
    frm_has_len = 1'b0;
    frm_len     = '0;
    frm_sum     = '0;
    frm_cmd     = '0;
  endfunction

  function automatic result_t next_status(logic [7:0] c);
    result_t r;
    int pay_start;
    int cks_pos;
    pay_start       = int'(frm_has_len) + 1;
    cks_pos         = int'(frm_len) + int'(frm_has_len) + 1;
    r.event_res     = EV_OVERFLOW;
    r.data_byte     = c;
    r.payload_index = '0;
    r.frame_length  = frm_len;
    r.command_byte  = '0;
    if (frm_pos + 1 >= FRAME_BOUND) begin
      clear_frame();
    end else if (frm_pos == 0) begin
      r.frame_length = '0;
      if ((c & HDR_TAG_MASK) == {hdr_tag, 4'h0}) begin
        r.event_res = EV_HDR_OK;
        frm_has_len = (c & HDR_LEN_FLAG) != 0;
        frm_sum     = c;
        frm_pos     = 1;
      end else begin
        r.event_res = EV_HDR_BAD;
        clear_frame();
      end
    end else if (frm_has_len && frm_pos == 1) begin
      r.event_res    = EV_LENGTH;
      frm_len        = c;
      r.frame_length = c;
      frm_sum        = frm_sum + c;
      frm_pos++;
    end else if (frm_pos >= pay_start && frm_pos < cks_pos) begin
      r.event_res     = EV_PAYLOAD;
      r.payload_index = 8'(frm_pos - pay_start);
      if (frm_pos == pay_start) frm_cmd = c;
      frm_sum = frm_sum + c;
      frm_pos++;
    end else if (frm_pos == cks_pos) begin
      if (frm_sum == c) begin
        r.event_res = EV_GOOD;
        if (frm_len != 0) r.command_byte = frm_cmd;
      end else begin
        r.event_res = EV_CKS_BAD;
      end
      clear_frame();
    end else begin
      clear_frame();
    end
    return r;
  endfunction

  task automatic add_byte(logic [7:0] v);
    stim_t s;
    s.is_cfg = 1'b0;
    s.steady = gen_steady;
    s.value  = v;
    pending.push_back(s);
    stim_count++;
  endtask

  task automatic add_cfg(logic [3:0] tag);
    stim_t s;
    s.is_cfg = 1'b1;
    s.steady = 1'b0;
    s.value  = {4'h0, tag};
    pending.push_back(s);
    gen_tag = tag;
  endtask

  // Lengths of 61 and above run into the buffer bound: 64 bytes are sent
  // and the 64th of them drops the frame, so no checksum is ever checked.
  task automatic add_frame(bit with_len, int len, bit corrupt);
    logic [7:0] hdr;
    logic [7:0] sum;
    logic [7:0] b;
    int n;
    hdr = {gen_tag, 3'($urandom_range(0, 7)), with_len};
    n   = with_len ? len : 0;
    add_byte(hdr);
    sum = hdr;
    if (with_len) begin
      add_byte(8'(len));
      sum = sum + 8'(len);
    end
    for (int i = 0; i < n && i < 62; i++) begin
      b = 8'($urandom);
      add_byte(b);
      sum = sum + b;
    end
    if (n <= 61) begin
      if (corrupt) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      add_byte(sum);
    end
  endtask

  always @(negedge clk) begin
    stim_t sent;
    logic  next_in_valid;
    logic  next_cfg_valid;
    if (rst_n) begin
      next_in_valid  = in_tvalid && !in_acc;
      next_cfg_valid = cfg_valid && !cfg_acc;
      if (in_acc || cfg_acc) begin
        sent = pending.pop_front();
        if (in_acc && !sent.steady) in_gap = pick_gap();
      end
      if (!next_in_valid && !next_cfg_valid && pending.size() != 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending[0].is_cfg) begin
          if (expected_status.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            next_cfg_valid = 1'b1;
            cfg_data <= pending[0].value[3:0];
          end
        end else begin
          next_in_valid = 1'b1;
          in_tdata <= pending[0].value;
        end
      end
      in_tvalid <= next_in_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      sink_cycles++;
      if (sink_cycles % 256 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      in_acc  <= in_tvalid && in_tready;
      cfg_acc <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) hdr_tag = cfg_data;
      if (in_tvalid && in_tready) expected_status.push_back(next_status(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_status.size() == 0) begin
          report_fault($sformatf("result transfer with nothing expected, data %02h",
                                 out_tdata[7:0]));
        end else begin
          want = expected_status.pop_front();
          if (out_tuser !== want.event_res)
            report_fault($sformatf("event: got %0d, want %0d", out_tuser, want.event_res));
          if (out_tdata[7:0] !== want.data_byte)
            report_fault($sformatf("data byte: got %02h, want %02h",
                                   out_tdata[7:0], want.data_byte));
          if (out_tdata[15:8] !== want.payload_index)
            report_fault($sformatf("payload index: got %0d, want %0d",
                                   out_tdata[15:8], want.payload_index));
          if (out_tdata[23:16] !== want.frame_length)
            report_fault($sformatf("frame length: got %0d, want %0d",
                                   out_tdata[23:16], want.frame_length));
          if (out_tdata[31:24] !== want.command_byte)
            report_fault($sformatf("command byte: got %02h, want %02h",
                                   out_tdata[31:24], want.command_byte));
        end
      end
      if (expected_status.size() == 0 && !in_tvalid) quiet_cycles++;
      else quiet_cycles = 0;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int pick;
    int frames;
    int phase_end;
    int len;
    int r;
    logic [3:0] tag;
    frames = 0;

    // Directed frames with the reset tag of zero.
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h0F);
    add_byte(8'h00);
    add_byte(8'h0F);
    // Directed frames with the tag at its top value.
    add_cfg(4'hF);
    add_byte(8'h0F);
    add_byte(8'hF1);
    add_byte(8'h02);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hF2);
    add_byte(8'hF0);
    add_byte(8'h00);
    add_byte(8'hF1);
    add_byte(8'h01);
    add_byte(8'h80);
    add_byte(8'h00);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: tag = 4'h0;
        1: tag = 4'(  $urandom);
        2: tag = 4'hF;
        3: tag = 4'h5;
        default: tag = 4'hA;
      endcase
      add_cfg(tag);
      phase_end = stim_count + PHASE_ITEMS;
      while (stim_count < phase_end) begin
        if ($urandom_range(0, 9) == 0) gen_steady = !gen_steady;
        frames++;
        pick = $urandom_range(0, 99);
        if (frames % 40 == 1) begin
          add_frame(1'b1, $urandom_range(61, 255), 1'b0);
        end else if (pick < 12) begin
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        end else begin
          r   = $urandom_range(0, 99);
          len = (r < 70) ? $urandom_range(0, 6) :
                (r < 95) ? $urandom_range(7, 40) : $urandom_range(41, 60);
          add_frame(1'($urandom_range(0, 1)), len, $urandom_range(0, 4) == 0);
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
